/* rtl/bvbd_pkg.sv */
// Shared types and constants for the binary volume boundary detector.
package bvbd_pkg;

    localparam int LEVEL_W     = 16;
    localparam int CFG_COL_W   = 9;
    localparam int CFG_ROW_W   = 9;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int COORD_W     = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd2;

    // One classified voxel: up to two result words
    typedef struct packed {
        logic               edge_bit;   // edge of the voxel one level down
        logic [LEVEL_W-1:0] level;      // level of the incoming voxel
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               has_prev;   // emits the result of the level below
        logic               has_own;    // final level: emits its own zero result
        logic               done;       // own result closes the volume
    } bvbd_rec_t;

    typedef struct packed {
        logic      push;
        bvbd_rec_t rec;
    } bvbd_push_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } bvbd_phase_t;

endpackage

/* rtl/binary_volume_boundary_detect.sv */
// Top level of the binary volume boundary detector (3D, six face neighbors).
//
// Input words carry one voxel each, in raster order: level slowest, then column, row
// fastest. Output words carry the edge flag of one voxel with its coordinates and a
// flag on the last word of the volume. Both channels are valid/ready.
// A voxel's result leaves when the same position of the next level arrives; voxels of
// the final level also give their own (always zero) result right after it.
// A word's results pass stage two, the queue and the output register before m_valid shows them.
// Throughput: one voxel per cycle while m_ready stays high and each voxel gives at most one word;
// in the final level of a volume with more than one level each voxel gives two words, and the
// single output register takes the next voxel's words only after both of them.
// Config writes (cfg_wr_en, cfg_wr_index, cfg_wr_data) take effect at once and restart
// the volume at position zero; write only while the block is idle.
// Reset sets all counts to one and the position to zero. The plane store is not
// cleared; only values written earlier in the current volume reach a result.
// When m_ready is low, results wait in a four-deep queue and the output register;
// s_ready drops once the queue cannot take another voxel.
module binary_volume_boundary_detect #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bvbd_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [bvbd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_voxel_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_edge_bit,
    output logic [bvbd_pkg::LEVEL_W-1:0]       m_out_level,
    output logic [bvbd_pkg::COORD_W-1:0]       m_out_column,
    output logic [bvbd_pkg::COORD_W-1:0]       m_out_row,
    output logic                               m_volume_done
);
    import bvbd_pkg::*;

    bvbd_push_t          q_push;
    bvbd_rec_t           head;
    logic                head_valid;
    logic                pop;
    logic [QCOUNT_W-1:0] q_count;

    // Front end: counters, store, classification
    bvbd_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_voxel_in   (s_voxel_in),
        .q_count      (q_count),
        .q_push       (q_push)
    );

    // Decoupling queue
    bvbd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_push     (q_push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .q_count    (q_count)
    );

    // Back end: result words
    bvbd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_bit    (m_edge_bit),
        .m_out_level   (m_out_level),
        .m_out_column  (m_out_column),
        .m_out_row     (m_out_row),
        .m_volume_done (m_volume_done)
    );

endmodule

/* rtl/bvbd_front.sv */
// Front end: config registers, position counters, plane store and edge classification.
module bvbd_front #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bvbd_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [bvbd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_voxel_in,
    input  logic [bvbd_pkg::QCOUNT_W-1:0]      q_count,
    output bvbd_pkg::bvbd_push_t               q_push
);
    import bvbd_pkg::*;

    localparam int CW         = $clog2(MAX_COLUMNS);
    localparam int RW         = $clog2(MAX_ROWS);
    localparam int CXW        = (CW + 1 > CFG_COL_W) ? CW + 1 : CFG_COL_W;
    localparam int RXW        = (RW + 1 > CFG_ROW_W) ? RW + 1 : CFG_ROW_W;
    localparam int AW         = CW + RW;
    localparam int MEM_DEPTH  = 1 << AW;
    localparam int LINE_DEPTH = 1 << RW;
    localparam int SUM_W      = QCOUNT_W + 1;

    // Config registers
    logic [LEVEL_W-1:0]   level_count_reg;
    logic [CFG_COL_W-1:0] column_count_reg;
    logic [CFG_ROW_W-1:0] row_count_reg;

    // Position of the next word
    logic [LEVEL_W-1:0] level_pos_reg, level_pos_next;
    logic [CW-1:0]      column_pos_reg, column_pos_next;
    logic [RW-1:0]      row_pos_reg, row_pos_next;

    logic run_reg;

    // Stores: plane store {older, newer} per position, column line {center, right} per row
    logic [1:0] plane_mem [MEM_DEPTH];
    logic [1:0] line_mem [LINE_DEPTH];
    logic [1:0] plane_rd_a_reg, plane_rd_b_reg;
    logic [1:0] line_rd_a_reg, line_rd_b_reg;

    // Second stage
    logic               s2_valid_reg;
    logic               s2_voxel_reg;
    logic [LEVEL_W-1:0] s2_level_reg;
    logic [CW-1:0]      s2_column_reg;
    logic [RW-1:0]      s2_row_reg;
    logic               s2_has_prev_reg;
    logic               s2_has_own_reg;
    logic               s2_interior_reg;
    logic               s2_done_reg;
    logic               prev_center_reg;

    logic [CXW-1:0]     col_raw, col_eff;
    logic [RXW-1:0]     row_raw, row_eff;
    logic [CW-1:0]      col_last;
    logic [RW-1:0]      row_last;
    logic [LEVEL_W-1:0] level_last;
    logic               accept;
    logic               col_hit, row_hit, lvl_hit;
    logic               has_prev, has_own, interior, done;
    logic [AW-1:0]      rd_addr_a, rd_addr_b;
    logic [CW-1:0]      column_inc;
    logic [RW-1:0]      row_inc;
    logic               center, below, rm, cm, rp, cp, edge_bit;

    // Effective dimensions: zero acts as one, oversize clamps to the maximum
    always_comb begin
        col_raw = CXW'(column_count_reg);
        row_raw = RXW'(row_count_reg);
        if (col_raw == '0) begin
            col_eff = CXW'(1);
        end else if (col_raw > CXW'(MAX_COLUMNS)) begin
            col_eff = CXW'(MAX_COLUMNS);
        end else begin
            col_eff = col_raw;
        end
        if (row_raw == '0) begin
            row_eff = RXW'(1);
        end else if (row_raw > RXW'(MAX_ROWS)) begin
            row_eff = RXW'(MAX_ROWS);
        end else begin
            row_eff = row_raw;
        end
        col_last   = CW'(col_eff - CXW'(1));
        row_last   = RW'(row_eff - RXW'(1));
        level_last = (level_count_reg == '0) ? '0 : level_count_reg - LEVEL_W'(1);
    end

    // Room for the word in stage two plus a new one
    assign s_ready = run_reg &&
        ((SUM_W'(q_count) + SUM_W'(s2_valid_reg)) < SUM_W'(QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;

    // Classification of the incoming word
    assign col_hit  = (column_pos_reg == col_last);
    assign row_hit  = (row_pos_reg == row_last);
    assign lvl_hit  = (level_pos_reg == level_last);
    assign has_prev = (level_pos_reg != '0);
    assign has_own  = lvl_hit;
    assign done     = lvl_hit && col_hit && row_hit;
    assign interior = (level_pos_reg >= LEVEL_W'(2)) &&
                      (column_pos_reg != '0) && (column_pos_reg < col_last) &&
                      (row_pos_reg != '0) && (row_pos_reg < row_last);

    // Raster position counters; any config write restarts the volume
    always_comb begin
        level_pos_next  = level_pos_reg;
        column_pos_next = column_pos_reg;
        row_pos_next    = row_pos_reg;
        if (cfg_wr_en) begin
            level_pos_next  = '0;
            column_pos_next = '0;
            row_pos_next    = '0;
        end else if (accept) begin
            if (row_hit) begin
                row_pos_next = '0;
                if (col_hit) begin
                    column_pos_next = '0;
                    level_pos_next  = lvl_hit ? '0 : level_pos_reg + LEVEL_W'(1);
                end else begin
                    column_pos_next = column_pos_reg + CW'(1);
                end
            end else begin
                row_pos_next = row_pos_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg  <= LEVEL_W'(1);
            column_count_reg <= CFG_COL_W'(1);
            row_count_reg    <= CFG_ROW_W'(1);
            level_pos_reg    <= '0;
            column_pos_reg   <= '0;
            row_pos_reg      <= '0;
            run_reg          <= 1'b0;
            s2_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_LEVEL_COUNT:  level_count_reg  <= cfg_wr_data;
                    REG_COLUMN_COUNT: column_count_reg <= cfg_wr_data[CFG_COL_W-1:0];
                    REG_ROW_COUNT:    row_count_reg    <= cfg_wr_data[CFG_ROW_W-1:0];
                    default: ;
                endcase
            end
            level_pos_reg  <= level_pos_next;
            column_pos_reg <= column_pos_next;
            row_pos_reg    <= row_pos_next;
            run_reg        <= 1'b1;
            s2_valid_reg   <= accept;
        end
    end

    // Stage-two payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_voxel_reg    <= s_voxel_in;
            s2_level_reg    <= level_pos_reg;
            s2_column_reg   <= column_pos_reg;
            s2_row_reg      <= row_pos_reg;
            s2_has_prev_reg <= has_prev;
            s2_has_own_reg  <= has_own;
            s2_interior_reg <= interior;
            s2_done_reg     <= done;
        end
        if (s2_valid_reg) begin
            prev_center_reg <= center;
        end
    end

    // Store reads: own position and right neighbor; column line at this row and the next
    assign column_inc = column_pos_reg + CW'(1);
    assign row_inc    = row_pos_reg + RW'(1);
    assign rd_addr_a  = {column_pos_reg, row_pos_reg};
    assign rd_addr_b  = {column_inc, row_pos_reg};

    always_ff @(posedge aclk) begin
        if (accept) begin
            plane_rd_a_reg <= plane_mem[rd_addr_a];
            plane_rd_b_reg <= plane_mem[rd_addr_b];
            line_rd_a_reg  <= line_mem[row_pos_reg];
            line_rd_b_reg  <= line_mem[row_inc];
        end
        if (s2_valid_reg) begin
            plane_mem[{s2_column_reg, s2_row_reg}] <= {center, s2_voxel_reg};
            line_mem[s2_row_reg]                   <= {center, cp};
        end
    end

    // Six-face test for the voxel one level down
    assign center   = plane_rd_a_reg[0];
    assign below    = plane_rd_a_reg[1];
    assign cp       = plane_rd_b_reg[0];
    assign cm       = line_rd_a_reg[1];
    assign rp       = line_rd_b_reg[0];
    assign rm       = prev_center_reg;
    assign edge_bit = s2_interior_reg && center &&
                      !(s2_voxel_reg && below && rm && cm && rp && cp);

    always_comb begin
        q_push.push         = s2_valid_reg && (s2_has_prev_reg || s2_has_own_reg);
        q_push.rec.edge_bit = edge_bit;
        q_push.rec.level    = s2_level_reg;
        q_push.rec.column   = COORD_W'(s2_column_reg);
        q_push.rec.row      = COORD_W'(s2_row_reg);
        q_push.rec.has_prev = s2_has_prev_reg;
        q_push.rec.has_own  = s2_has_own_reg;
        q_push.rec.done     = s2_done_reg;
    end

endmodule

/* rtl/bvbd_queue.sv */
// Short queue of classified words between front and back ends.
module bvbd_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bvbd_pkg::bvbd_push_t           q_push,
    input  logic                           pop,
    output bvbd_pkg::bvbd_rec_t            head,
    output logic                           head_valid,
    output logic [bvbd_pkg::QCOUNT_W-1:0]  q_count
);
    import bvbd_pkg::*;

    bvbd_rec_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg;

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign q_count    = count_reg;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_push.push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (q_push.push && !pop) begin
                count_reg <= count_reg + QCOUNT_W'(1);
            end else if (pop && !q_push.push) begin
                count_reg <= count_reg - QCOUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push.push) begin
            slot_reg[wr_ptr_reg] <= q_push.rec;
        end
    end

endmodule

/* rtl/bvbd_back.sv */
// Back end: splits each queued record into result words and drives the output register.
module bvbd_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bvbd_pkg::bvbd_rec_t                head,
    input  logic                               head_valid,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_edge_bit,
    output logic [bvbd_pkg::LEVEL_W-1:0]       m_out_level,
    output logic [bvbd_pkg::COORD_W-1:0]       m_out_column,
    output logic [bvbd_pkg::COORD_W-1:0]       m_out_row,
    output logic                               m_volume_done
);
    import bvbd_pkg::*;

    bvbd_phase_t        phase_reg, phase_next;
    logic               m_valid_reg;
    logic               edge_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [COORD_W-1:0] column_reg;
    logic [COORD_W-1:0] row_reg;
    logic               done_reg;

    logic               load;
    logic               emit_prev;
    logic               word_edge;
    logic [LEVEL_W-1:0] word_level;
    logic               word_done;

    assign load = head_valid && (!m_valid_reg || m_ready);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_FIRST: begin
                if (load && head.has_prev && head.has_own) begin
                    phase_next = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (load) begin
                    phase_next = PH_FIRST;
                end
            end
            default: phase_next = PH_FIRST;
        endcase
    end

    // Word selection: level-below result first, then own result
    always_comb begin
        emit_prev  = head.has_prev && (phase_reg == PH_FIRST);
        pop        = load && (!emit_prev || !head.has_own);
        if (emit_prev) begin
            word_edge  = head.edge_bit;
            word_level = head.level - LEVEL_W'(1);
            word_done  = 1'b0;
        end else begin
            word_edge  = 1'b0;
            word_level = head.level;
            word_done  = head.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            edge_reg   <= word_edge;
            level_reg  <= word_level;
            column_reg <= head.column;
            row_reg    <= head.row;
            done_reg   <= word_done;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_edge_bit    = edge_reg;
    assign m_out_level   = level_reg;
    assign m_out_column  = column_reg;
    assign m_out_row     = row_reg;
    assign m_volume_done = done_reg;

endmodule
